// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== src/gf128m_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gf128m_pkg;

  localparam int WORD_W = 64;
  localparam int ELEM_W = 2 * WORD_W;

  // Reduction term folded into the top byte on a right shift.
  localparam logic [ELEM_W-1:0] REDUCE_TOP = {8'hE1, {(ELEM_W - 8){1'b0}}};

  // Multiply steps done in one pipeline stage.
  localparam int STEPS_PER_STAGE_DEF = 8;

endpackage
`default_nettype wire

// ===== src/gf128m_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gf128m_in_if
  import gf128m_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] x_high;
  logic [WORD_W-1:0] x_low;
  logic [WORD_W-1:0] y_high;
  logic [WORD_W-1:0] y_low;

  modport source (output valid, x_high, x_low, y_high, y_low, input ready);
  modport sink   (input valid, x_high, x_low, y_high, y_low, output ready);
endinterface
`default_nettype wire

// ===== src/gf128m_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gf128m_out_if
  import gf128m_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] z_high;
  logic [WORD_W-1:0] z_low;

  modport source (output valid, z_high, z_low, input ready);
  modport sink   (input valid, z_high, z_low, output ready);
endinterface
`default_nettype wire

// ===== src/gf128_multiply.sv =====
// GHASH multiplier over GF(2^128), bit-reflected GCM convention.
//
// in_ch carries one word of two operands, X = {x_high, x_low} and
// Y = {y_high, y_low}; out_ch returns Z = X * Y as {z_high, z_low},
// reduced by x^128 + x^7 + x^2 + x + 1. One result per input word, in order.
//
// Structure: 128 shift-and-add steps, STEPS_PER_STAGE of them in each
// register stage, so there are 128 / STEPS_PER_STAGE stages (16 by default).
// An accepted word moves through the stage registers in order; out_ch.valid
// rises when it is in the last one. Throughput is one word per cycle unless
// out_ch stalls while every stage is full; each stage holds its own valid bit.
//
// Back-pressure: a stage takes a new word when it is empty or the stage
// after it moves on, so bubbles are squeezed out and in_ch stays ready
// while any stage is free, even when out_ch is stalled. A stalled result
// sits in the last stage register unchanged until out_ch.ready.
//
// Reset (rst_n low, synchronous) empties all stages; words in flight are
// dropped. The datapath has no other state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gf128_multiply
  import gf128m_pkg::*;
#(
  parameter int STEPS_PER_STAGE = STEPS_PER_STAGE_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  gf128m_in_if.sink     in_ch,
  gf128m_out_if.source  out_ch
);

  localparam int Stages = ELEM_W / STEPS_PER_STAGE;
  localparam int CntW   = $clog2(Stages + 1);

  // per-stage registers: accumulator, running multiplicand, multiplier bits
  logic [Stages-1:0]             valid_r;
  logic [ELEM_W-1:0]             z_r [Stages];
  logic [ELEM_W-1:0]             v_r [Stages];
  logic [ELEM_W-1:0]             x_r [Stages];

  // ready[s]: stage s may load this cycle; ready[Stages] is the consumer
  logic [Stages:0]               ready;

  assign ready[Stages] = out_ch.ready;

  genvar s;
  generate
    for (s = 0; s < Stages; s++) begin : g_stage
      logic              src_valid;
      logic [ELEM_W-1:0] src_z;
      logic [ELEM_W-1:0] src_v;
      logic [ELEM_W-1:0] src_x;
      logic [ELEM_W-1:0] z_nxt;
      logic [ELEM_W-1:0] v_nxt;

      if (s == 0) begin : g_src_in
        assign src_valid = in_ch.valid;
        assign src_z     = '0;
        assign src_v     = {in_ch.y_high, in_ch.y_low};
        assign src_x     = {in_ch.x_high, in_ch.x_low};
      end else begin : g_src_prev
        assign src_valid = valid_r[s-1];
        assign src_z     = z_r[s-1];
        assign src_v     = v_r[s-1];
        assign src_x     = x_r[s-1];
      end

      assign ready[s] = !valid_r[s] || ready[s+1];

      // STEPS_PER_STAGE steps, multiplier bits taken MSB first
      always_comb begin
        logic [ELEM_W-1:0] z;
        logic [ELEM_W-1:0] v;
        z = src_z;
        v = src_v;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
          if (src_x[ELEM_W - 1 - s * STEPS_PER_STAGE - k]) begin
            z = z ^ v;
          end
          v = v[0] ? ((v >> 1) ^ REDUCE_TOP) : (v >> 1);
        end
        z_nxt = z;
        v_nxt = v;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else if (ready[s]) begin
          valid_r[s] <= src_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (ready[s] && src_valid) begin
          z_r[s] <= z_nxt;
          v_r[s] <= v_nxt;
          x_r[s] <= src_x;
        end
      end
    end
  endgenerate

  assign in_ch.ready   = ready[0];
  assign out_ch.valid  = valid_r[Stages-1];
  assign out_ch.z_high = z_r[Stages-1][ELEM_W-1:WORD_W];
  assign out_ch.z_low  = z_r[Stages-1][WORD_W-1:0];

  // words in flight, kept for checking the valid bits
  logic            in_acc;
  logic            out_acc;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_CLK(a_cnt_match, clk, rst_n, cnt_r == CntW'($countones(valid_r)), "word count mismatch")
  `ASSERT_IMP(a_full_blocks, clk, rst_n, (&valid_r) && !out_ch.ready, !in_ch.ready, "full pipe took a word")
  `ASSERT_IMP(a_free_takes, clk, rst_n, !(&valid_r), in_ch.ready, "free stage but input blocked")

endmodule
`default_nettype wire
